>>> rtl/core/indexed_list_insert_remove_defines.svh
// Assertion macros used by the top level of the positional list store.
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILIR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilir assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilir assertion failed in the next cycle");

`endif

>>> rtl/core/ilir_pkg.sv
// Package with the codes, widths and shared types of the positional list store.
`timescale 1ns / 1ps

package ilir_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } ctrl_cmd_t;

endpackage

>>> rtl/core/ilir_ctrl.sv
// Controller state machine that sequences word capture, execution and result hand-off.
`timescale 1ns / 1ps

module ilir_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output ilir_pkg::ctrl_cmd_t ctrl
);
    import ilir_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        ctrl.load_in = 1'b0;
        ctrl.exec    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                ctrl.load_in = in_valid;
            end
            S_EXEC:
            begin
                ctrl.exec = out_free;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/ilir_dp.sv
// Datapath with the shifting cell row, the element count and the result registers.
`timescale 1ns / 1ps

module ilir_dp #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ilir_pkg::ctrl_cmd_t             ctrl,
    input  logic [ilir_pkg::CMD_W-1:0]      cmd,
    input  logic [ilir_pkg::POS_W-1:0]      position,
    input  logic [ilir_pkg::VAL_W-1:0]      new_value,
    output logic [ilir_pkg::VAL_W-1:0]      removed_value,
    output logic [ilir_pkg::STATUS_W-1:0]   status,
    output logic [ilir_pkg::FILL_W-1:0]     fill_count,
    output logic                            is_empty
);
    import ilir_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CMD_W-1:0]         cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic [ELEMENT_WIDTH-1:0] cell_reg [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] cell_next [CAPACITY];

    logic [VAL_W-1:0]         removed_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic                     empty_reg;

    logic [VAL_W+ELEMENT_WIDTH-1:0] val_wide;
    logic [VAL_W+ELEMENT_WIDTH-1:0] taken_wide;
    logic [CW+FILL_W-1:0]           fill_wide;
    logic [CMPW-1:0]                pos_ext;
    logic [CMPW-1:0]                cnt_ext;
    logic [ELEMENT_WIDTH-1:0]       taken;
    logic [STATUS_W-1:0]            status_next;
    logic                           ins_ok;
    logic                           rem_ok;
    logic                           clr_ok;

    assign val_wide = (VAL_W + ELEMENT_WIDTH)'(new_value);
    assign pos_ext  = CMPW'(pos_reg);
    assign cnt_ext  = CMPW'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            val_reg <= val_wide[ELEMENT_WIDTH-1:0];
        end
    end

    always_comb
    begin
        ins_ok      = 1'b0;
        rem_ok      = 1'b0;
        clr_ok      = 1'b0;
        status_next = STAT_OK;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    status_next = STAT_BAD;
                end
                else if (cnt_reg >= CAP_CNT)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = STAT_BAD;
                end
                else
                begin
                    rem_ok = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                clr_ok = 1'b1;
            end
            default:
            begin
                status_next = STAT_BAD;
            end
        endcase
    end

    always_comb
    begin
        priority if (clr_ok)
        begin
            cnt_next = '0;
        end
        else if (ins_ok)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // On insert cells above the position take their lower neighbour, on remove cells from it the upper.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (ins_ok)
            begin
                if (i > 0 && CMPW'(i) > pos_ext)
                begin
                    cell_next[i] = cell_reg[i-1];
                end
                else if (CMPW'(i) == pos_ext)
                begin
                    cell_next[i] = val_reg;
                end
            end
            else if (rem_ok)
            begin
                if (i < CAPACITY - 1 && CMPW'(i) >= pos_ext)
                begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    assign taken      = rem_ok ? cell_reg[pos_ext[AW-1:0]] : '0;
    assign taken_wide = (VAL_W + ELEMENT_WIDTH)'(taken);
    assign fill_wide  = (CW + FILL_W)'(cnt_next);

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            cell_reg    <= cell_next;
            removed_reg <= taken_wide[VAL_W-1:0];
            status_reg  <= status_next;
            fill_reg    <= fill_wide[FILL_W-1:0];
            empty_reg   <= (cnt_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign fill_count    = fill_reg;
    assign is_empty      = empty_reg;

endmodule

>>> rtl/core/indexed_list_insert_remove.sv
// Top level of the positional list store with insert, remove and clear.
// A word is captured in the idle state and executed in the execute state once the result
// registers are free, and execution registers its result; the next word is taken once
// execution has finished, so the block takes no new word while it still holds the last one.
// Reset clears the element count and the result valid flag; cells stay undefined.
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_defines.svh"

module indexed_list_insert_remove #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ilir_pkg::CMD_W-1:0]      cmd,
    input  logic [ilir_pkg::POS_W-1:0]      position,
    input  logic [ilir_pkg::VAL_W-1:0]      new_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ilir_pkg::VAL_W-1:0]      removed_value,
    output logic [ilir_pkg::STATUS_W-1:0]   status,
    output logic [ilir_pkg::FILL_W-1:0]     fill_count,
    output logic                            is_empty
);
    import ilir_pkg::*;

    ctrl_cmd_t ctrl;

    ilir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    ilir_dp #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cmd           (cmd),
        .position      (position),
        .new_value     (new_value),
        .removed_value (removed_value),
        .status        (status),
        .fill_count    (fill_count),
        .is_empty      (is_empty)
    );

    `ILIR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ILIR_ASSERT_SAME(a_empty_count, clk, rst_n, out_valid && is_empty, fill_count == '0)
    `ILIR_ASSERT_SAME(a_full_not_empty, clk, rst_n, out_valid && status == STAT_FULL, !is_empty)
    `ILIR_ASSERT_SAME(a_removed_only_ok, clk, rst_n, out_valid && removed_value != '0, status == STAT_OK)

endmodule

>>> tb/tb_indexed_list_insert_remove.sv
// Self-checking testbench for the positional list store, with a directed table and random words.
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove;

    import ilir_pkg::*;

    localparam int CAPACITY = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 405;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [VAL_W-1:0]    removed_value;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_count;
        logic                is_empty;
    } list_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] new_value;
        int               repeats;
        bit               typed;
        list_result_t     want;
    } list_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd = CMD_CLEAR;
    logic [POS_W-1:0]    position = '0;
    logic [VAL_W-1:0]    new_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VAL_W-1:0]    removed_value;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;
    logic                is_empty;

    logic [VAL_W-1:0] model_cells [CAPACITY];
    int unsigned      model_len = 0;
    list_result_t     pending_results [$];
    int               error_count = 0;
    int               send_idle_pct = 27;
    int               recv_stall_pct = 59;
    bit               long_hold_req = 1'b0;
    list_row_t        directed_rows [21];

    indexed_list_insert_remove i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .position      (position),
        .new_value     (new_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .fill_count    (fill_count),
        .is_empty      (is_empty)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] c,
                                                        input logic [POS_W-1:0] p,
                                                        input logic [VAL_W-1:0] v);
        list_result_t r;
        int unsigned  i;
        r.removed_value = '0;
        r.status = STAT_OK;
        if (c == CMD_INSERT)
        begin
            if (p > model_len)
                r.status = STAT_BAD;
            else if (model_len >= CAPACITY)
                r.status = STAT_FULL;
            else
            begin
                for (i = model_len; i > p; i--)
                    model_cells[i] = model_cells[i-1];
                model_cells[p] = v;
                model_len++;
            end
        end
        else if (c == CMD_REMOVE)
        begin
            if (p >= model_len)
                r.status = STAT_BAD;
            else
            begin
                r.removed_value = model_cells[p];
                for (i = p; i + 1 < model_len; i++)
                    model_cells[i] = model_cells[i+1];
                model_len--;
            end
        end
        else if (c == CMD_CLEAR)
            model_len = 0;
        else
            r.status = STAT_BAD;
        r.fill_count = model_len[FILL_W-1:0];
        r.is_empty = (model_len == 0);
        return r;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v, input bit typed,
                             input list_result_t want);
        list_result_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        cmd <= c;
        position <= p;
        new_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_list_command(c, p, v);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic send_random_word(input int bias_step);
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        logic [VAL_W-1:0] v;
        int               pick;
        int               insert_pct;
        insert_pct = ((bias_step / 100) % 2 == 0) ? 58 : 36;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            c = CMD_INSERT;
        else if (pick < 95)
            c = CMD_REMOVE;
        else if (pick < 98)
            c = CMD_CLEAR;
        else
            c = CMD_UNUSED;
        if ($urandom_range(99) < 12)
            p = POS_W'($urandom_range(31));
        else if (c == CMD_INSERT)
            p = POS_W'($urandom_range(model_len, 0));
        else if (c == CMD_REMOVE && model_len > 0)
            p = POS_W'($urandom_range(model_len - 1, 0));
        else
            p = POS_W'($urandom_range(31));
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            default: v = $urandom;
        endcase
        send_word(c, p, v, 1'b0, '0);
    endtask

    task automatic wait_for_results;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    always
    begin
        @(negedge clk);
        if (long_hold_req)
        begin
            out_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clk);
            long_hold_req = 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (removed_value !== want.removed_value)
                begin
                    $error("removed_value: expected %h, got %h", want.removed_value,
                           removed_value);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
                    error_count++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0b, got %0b", want.is_empty, is_empty);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int k;
        int phase;
        directed_rows = '{
            '{CMD_REMOVE, 5'd0, 32'h0, 1, 1'b1, '{32'h0, STAT_BAD, 5'd0, 1'b1}},
            '{CMD_CLEAR, 5'd0, 32'h0, 1, 1'b1, '{32'h0, STAT_OK, 5'd0, 1'b1}},
            '{CMD_INSERT, 5'd1, 32'h1111_1111, 1, 1'b1, '{32'h0, STAT_BAD, 5'd0, 1'b1}},
            '{CMD_UNUSED, 5'd31, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, STAT_BAD, 5'd0, 1'b1}},
            '{CMD_INSERT, 5'd0, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, STAT_OK, 5'd1, 1'b0}},
            '{CMD_INSERT, 5'd0, 32'h0, 1, 1'b1, '{32'h0, STAT_OK, 5'd2, 1'b0}},
            '{CMD_INSERT, 5'd2, 32'hA5A5_A5A5, 1, 1'b0, '0},
            '{CMD_INSERT, 5'd1, 32'h5A5A_5A5A, 1, 1'b0, '0},
            '{CMD_REMOVE, 5'd31, 32'h0, 1, 1'b1, '{32'h0, STAT_BAD, 5'd4, 1'b0}},
            '{CMD_REMOVE, 5'd3, 32'h0, 1, 1'b0, '0},
            '{CMD_REMOVE, 5'd0, 32'h0, 1, 1'b0, '0},
            '{CMD_INSERT, 5'd0, 32'h0BAD_0000, 14, 1'b0, '0},
            '{CMD_INSERT, 5'd16, 32'h1234_5678, 1, 1'b1, '{32'h0, STAT_FULL, 5'd16, 1'b0}},
            '{CMD_INSERT, 5'd17, 32'h1234_5678, 1, 1'b1, '{32'h0, STAT_BAD, 5'd16, 1'b0}},
            '{CMD_REMOVE, 5'd16, 32'h0, 1, 1'b1, '{32'h0, STAT_BAD, 5'd16, 1'b0}},
            '{CMD_REMOVE, 5'd15, 32'h0, 1, 1'b0, '0},
            '{CMD_INSERT, 5'd15, 32'hC0DE_0001, 1, 1'b0, '0},
            '{CMD_REMOVE, 5'd0, 32'h0, 1, 1'b0, '0},
            '{CMD_INSERT, 5'd0, 32'h8000_0001, 1, 1'b0, '0},
            '{CMD_CLEAR, 5'd0, 32'h0, 1, 1'b1, '{32'h0, STAT_OK, 5'd0, 1'b1}},
            '{CMD_REMOVE, 5'd0, 32'h0, 1, 1'b1, '{32'h0, STAT_BAD, 5'd0, 1'b1}}
        };
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (r = 0; r < $size(directed_rows); r++)
            for (k = 0; k < directed_rows[r].repeats; k++)
                send_word(directed_rows[r].cmd, directed_rows[r].position,
                          directed_rows[r].new_value + k, directed_rows[r].typed,
                          directed_rows[r].want);
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
            begin
                in_valid <= 1'b0;
                wait_for_results();
            end
            if (phase == 1)
            begin
                send_idle_pct = 59;
                recv_stall_pct = 27;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                long_hold_req = 1'b1;
            end
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                send_random_word(k);
        end
        in_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_indexed_list_insert_remove OK");
        else
            $display("tb_indexed_list_insert_remove NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_indexed_list_insert_remove NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ilir_pkg.sv
rtl/core/ilir_ctrl.sv
rtl/core/ilir_dp.sv
rtl/core/indexed_list_insert_remove.sv
tb/tb_indexed_list_insert_remove.sv
